// ===== rtl/fast_packet_reassembler_defines.svh =====
// Assertion macros for the fast-packet reassembler.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef FAST_PACKET_REASSEMBLER_DEFINES_SVH
`define FAST_PACKET_REASSEMBLER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FPR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fpr_pkg.sv =====
// Package of the fast-packet reassembler: request types and sizing constants.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package fpr_pkg;

  localparam int unsigned BufferBytes = 256;
  localparam int unsigned BufAw       = (BufferBytes > 1) ? $clog2(BufferBytes) : 1;
  localparam logic [8:0]  BufLimit    = 9'(BufferBytes);

  localparam logic [4:0] FrameIdxFirst = 5'd0;
  localparam logic [7:0] FirstBytes    = 8'd6;
  localparam logic [7:0] ContBytes     = 8'd7;
  localparam logic [2:0] FirstOffset   = 3'd2;
  localparam logic [2:0] ContOffset    = 3'd1;

  typedef struct packed {
    logic [17:0] pgn;
    logic [7:0]  source_address;
    logic [7:0]  data_byte_0;
    logic [7:0]  data_byte_1;
    logic [7:0]  data_byte_2;
    logic [7:0]  data_byte_3;
    logic [7:0]  data_byte_4;
    logic [7:0]  data_byte_5;
    logic [7:0]  data_byte_6;
    logic [7:0]  data_byte_7;
  } frame_t;

  typedef struct packed {
    logic [17:0] message_pgn;
    logic [7:0]  message_source;
    logic [7:0]  message_length;
    logic [4:0]  chunk_index;
    logic [63:0] chunk_data;
    logic        last_chunk;
  } chunk_t;

endpackage

`default_nettype wire

// ===== rtl/fpr_frame_if.sv =====
// Input channel of the fast-packet reassembler: one CAN frame per request.
// Depends on fpr_pkg for the frame type.
`default_nettype none

interface fpr_frame_if;
  import fpr_pkg::*;

  logic   valid;
  logic   ready;
  frame_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/fpr_chunk_if.sv =====
// Output channel of the fast-packet reassembler: one 64-bit message chunk per request.
// Depends on fpr_pkg for the chunk type.
`default_nettype none

interface fpr_chunk_if;
  import fpr_pkg::*;

  logic   valid;
  logic   ready;
  chunk_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/fast_packet_reassembler.sv =====
// Top level of the fast-packet reassembler: control, byte store and chunk output.
// Depends on fpr_pkg, fpr_frame_if, fpr_chunk_if and the assertion macro header.
//
// Frames are taken one at a time. After a frame is accepted, its payload bytes, up
// to seven, are stored one by one (StWrite), since the message store has a single
// byte-wide write port. A completed message is read back byte by byte through the
// same store: each 64-bit chunk takes eight reads, a state for the last read to
// land and a state to load the output register, plus any time the output stalls.
// The last chunk waits in the output register while the next frame is accepted.
`default_nettype none

`include "fast_packet_reassembler_defines.svh"

module fast_packet_reassembler (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fpr_frame_if.sink   frame_i,
  fpr_chunk_if.source chunk_o
);
  import fpr_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StWrite = 3'd1;
  localparam logic [2:0] StRd    = 3'd2;
  localparam logic [2:0] StDrain = 3'd3;
  localparam logic [2:0] StLoad  = 3'd4;

  logic [2:0]  state_q, state_d;
  logic        assembling_q, error_q;
  logic [2:0]  seq_q;
  logic [7:0]  exp_len_q, filled_q;
  logic [17:0] pgn_q;
  logic [7:0]  src_q;
  logic        done_q;
  logic [7:0]  frame_q [8];
  logic [2:0]  off_q, n_q, wr_cnt_q;
  logic [7:0]  base_q;
  logic [4:0]  chunk_idx_q;
  logic [2:0]  k_q;
  logic        rd_vld_q, rd_zero_q;
  logic [2:0]  rd_k_q;
  logic [7:0]  rd_data_q;
  logic [7:0]  asm_q [8];
  logic        out_vld_q;
  chunk_t      out_q;
  logic [7:0]  store_mem [BufferBytes];

  logic        accept, first, match;
  logic [2:0]  seq_in, n_first, n_cont, n_new;
  logic [7:0]  rem, filled_new, len_new;
  logic        done_new;
  logic [7:0]  wr_addr, rd_addr;
  logic        wr_en, rd_en, rd_zero;
  logic [2:0]  wr_idx;
  logic [4:0]  last_idx;
  logic        asm_last, load;
  logic [63:0] asm_data;

  assign accept  = frame_i.valid && frame_i.ready;
  assign first   = frame_i.payload.data_byte_0[4:0] == FrameIdxFirst;
  assign seq_in  = frame_i.payload.data_byte_0[7:5];
  assign match   = !error_q && seq_in == seq_q && frame_i.payload.source_address == src_q
                   && frame_i.payload.pgn == pgn_q;
  assign n_first = (frame_i.payload.data_byte_1 < FirstBytes) ?
                   frame_i.payload.data_byte_1[2:0] : FirstBytes[2:0];
  assign rem     = exp_len_q - filled_q;
  assign n_cont  = (rem < ContBytes) ? rem[2:0] : ContBytes[2:0];
  assign n_new   = first ? n_first : n_cont;
  assign len_new = first ? frame_i.payload.data_byte_1 : exp_len_q;
  assign filled_new = first ? {5'd0, n_first} : filled_q + {5'd0, n_cont};
  assign done_new   = filled_new == len_new;

  assign wr_idx  = off_q + wr_cnt_q;
  assign wr_addr = base_q + {5'd0, wr_cnt_q};
  assign wr_en   = state_q == StWrite && {1'b0, wr_addr} < BufLimit;
  assign rd_addr = {chunk_idx_q, k_q};
  assign rd_en   = state_q == StRd;
  assign rd_zero = rd_addr >= exp_len_q || {1'b0, rd_addr} >= BufLimit;

  assign last_idx = (exp_len_q == 8'd0) ? 5'd0 : 5'((exp_len_q - 8'd1) >> 3);
  assign asm_last = chunk_idx_q == last_idx;
  assign load     = state_q == StLoad && (!out_vld_q || chunk_o.ready);

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      asm_data[8*b +: 8] = asm_q[b];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept && (first || (assembling_q && match))) begin
          if (n_new != 3'd0) begin
            state_d = StWrite;
          end else if (done_new) begin
            state_d = StRd;
          end
        end
      end
      StWrite: begin
        if (wr_cnt_q == n_q - 3'd1) begin
          state_d = done_q ? StRd : StIdle;
        end
      end
      StRd: begin
        if (k_q == 3'd7) begin
          state_d = StDrain;
        end
      end
      StDrain: state_d = StLoad;
      StLoad: begin
        if (load) begin
          state_d = asm_last ? StIdle : StRd;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      assembling_q <= 1'b0;
      error_q      <= 1'b0;
      seq_q        <= 3'd0;
      exp_len_q    <= 8'd0;
      filled_q     <= 8'd0;
      pgn_q        <= 18'd0;
      src_q        <= 8'd0;
      done_q       <= 1'b0;
      wr_cnt_q     <= 3'd0;
      chunk_idx_q  <= 5'd0;
      k_q          <= 3'd0;
      rd_vld_q     <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_en;
      if (accept) begin
        if (first) begin
          error_q      <= 1'b0;
          assembling_q <= !done_new;
          seq_q        <= seq_in;
          exp_len_q    <= frame_i.payload.data_byte_1;
          pgn_q        <= frame_i.payload.pgn;
          src_q        <= frame_i.payload.source_address;
          filled_q     <= filled_new;
          done_q       <= done_new;
        end else if (assembling_q) begin
          if (match) begin
            assembling_q <= !done_new;
            filled_q     <= filled_new;
            done_q       <= done_new;
          end else begin
            error_q <= 1'b1;
          end
        end
      end
      if (state_q == StIdle) begin
        wr_cnt_q    <= 3'd0;
        chunk_idx_q <= 5'd0;
        k_q         <= 3'd0;
      end else if (state_q == StWrite) begin
        wr_cnt_q <= wr_cnt_q + 3'd1;
      end else if (state_q == StRd) begin
        k_q <= k_q + 3'd1;
      end else if (load) begin
        chunk_idx_q <= chunk_idx_q + 5'd1;
      end
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (chunk_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      frame_q[0] <= frame_i.payload.data_byte_0;
      frame_q[1] <= frame_i.payload.data_byte_1;
      frame_q[2] <= frame_i.payload.data_byte_2;
      frame_q[3] <= frame_i.payload.data_byte_3;
      frame_q[4] <= frame_i.payload.data_byte_4;
      frame_q[5] <= frame_i.payload.data_byte_5;
      frame_q[6] <= frame_i.payload.data_byte_6;
      frame_q[7] <= frame_i.payload.data_byte_7;
      off_q      <= first ? FirstOffset : ContOffset;
      base_q     <= first ? 8'd0 : filled_q;
      n_q        <= n_new;
    end
    if (rd_en) begin
      rd_k_q    <= k_q;
      rd_zero_q <= rd_zero;
    end
    if (rd_vld_q) begin
      asm_q[rd_k_q] <= rd_zero_q ? 8'd0 : rd_data_q;
    end
    if (load) begin
      out_q.message_pgn    <= pgn_q;
      out_q.message_source <= src_q;
      out_q.message_length <= exp_len_q;
      out_q.chunk_index    <= chunk_idx_q;
      out_q.chunk_data     <= asm_data;
      out_q.last_chunk     <= asm_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[wr_addr[BufAw-1:0]] <= frame_q[wr_idx];
    end
    if (rd_en) begin
      rd_data_q <= store_mem[rd_addr[BufAw-1:0]];
    end
  end

  assign frame_i.ready   = state_q == StIdle;
  assign chunk_o.valid   = out_vld_q;
  assign chunk_o.payload = out_q;

  `FPR_ASSERT_NOW(a_write_in_range, state_q == StWrite, wr_cnt_q < n_q, "store write past frame count")
  `FPR_ASSERT_NOW(a_read_follows_issue, rd_vld_q, $past(state_q) == StRd, "read data without a read")
  `FPR_ASSERT_NOW(a_no_overwrite, load, !(out_vld_q && !chunk_o.ready), "chunk overwritten while held")
  `FPR_ASSERT_NEXT(a_emit_clears, state_q == StRd, !assembling_q, "message still open during emission")

endmodule

`default_nettype wire

// ===== tb/sv/fpr_reassembly_checker.sv =====
// Reassembly checker: watches the frame and chunk channels of the fast-packet reassembler,
// works out the chunks each accepted frame request should cause and compares them in order.
// Depends on fpr_pkg, fpr_frame_if and fpr_chunk_if.
`default_nettype none

module fpr_reassembly_checker
  import fpr_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  fpr_frame_if        frame_i,
  fpr_chunk_if        chunk_i,
  output int unsigned mismatch_count_o,
  output int unsigned chunks_pending_o
);

  logic        busy_q;
  logic        broken_q;
  logic [2:0]  seq_q;
  logic [7:0]  total_q;
  logic [7:0]  fill_q;
  logic [17:0] pgn_q;
  logic [7:0]  src_q;
  logic [7:0]  msg_bytes [BufferBytes];
  chunk_t      expected_chunks [$];

  task automatic queue_message();
    int unsigned n_chunks;
    int unsigned ci;
    int unsigned k;
    logic [63:0] data;
    chunk_t      c;
    n_chunks = (int'(total_q) + 7) / 8;
    if (n_chunks == 0) n_chunks = 1;
    for (ci = 0; ci < n_chunks; ci++) begin
      data = '0;
      for (k = 0; k < 8; k++) begin
        if (ci * 8 + k < total_q) data[8*k +: 8] = msg_bytes[ci * 8 + k];
      end
      c.message_pgn    = pgn_q;
      c.message_source = src_q;
      c.message_length = total_q;
      c.chunk_index    = 5'(ci);
      c.chunk_data     = data;
      c.last_chunk     = (ci + 1 == n_chunks);
      expected_chunks.push_back(c);
    end
    busy_q = 1'b0;
  endtask

  task automatic absorb_frame(input frame_t f);
    logic [7:0]  fb [8];
    int unsigned take;
    int unsigned i;
    fb[0] = f.data_byte_0;
    fb[1] = f.data_byte_1;
    fb[2] = f.data_byte_2;
    fb[3] = f.data_byte_3;
    fb[4] = f.data_byte_4;
    fb[5] = f.data_byte_5;
    fb[6] = f.data_byte_6;
    fb[7] = f.data_byte_7;
    if (fb[0][4:0] == FrameIdxFirst) begin
      broken_q = 1'b0;
      busy_q   = 1'b1;
      seq_q    = fb[0][7:5];
      total_q  = fb[1];
      pgn_q    = f.pgn;
      src_q    = f.source_address;
      take     = (total_q < FirstBytes) ? total_q : FirstBytes;
      for (i = 0; i < take; i++) msg_bytes[i] = fb[2 + i];
      fill_q = 8'(take);
      if (fill_q == total_q) queue_message();
    end else if (busy_q) begin
      if (broken_q || fb[0][7:5] != seq_q || f.source_address != src_q || f.pgn != pgn_q) begin
        broken_q = 1'b1;
      end else begin
        take = (total_q - fill_q > ContBytes) ? ContBytes : total_q - fill_q;
        for (i = 0; i < take; i++) msg_bytes[int'(fill_q) + i] = fb[1 + i];
        fill_q = fill_q + 8'(take);
        if (fill_q == total_q) queue_message();
      end
    end
  endtask

  function automatic void check_field(input string name, input logic [4:0] idx,
                                      input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      mismatch_count_o++;
      if (mismatch_count_o <= 10) begin
        $display("chunk %0d, %s: expected 0x%0h, got 0x%0h", idx, name, want, got);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    chunk_t want;
    chunk_t got;
    if (!rst_ni) begin
      busy_q   = 1'b0;
      broken_q = 1'b0;
      seq_q    = '0;
      total_q  = '0;
      fill_q   = '0;
      pgn_q    = '0;
      src_q    = '0;
      expected_chunks.delete();
      mismatch_count_o = 0;
      chunks_pending_o <= 0;
    end else begin
      if (chunk_i.valid && chunk_i.ready) begin
        got = chunk_i.payload;
        if (expected_chunks.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10) begin
            $display("chunk %0d arrived with no message outstanding, data 0x%0h",
                     got.chunk_index, got.chunk_data);
          end
        end else begin
          want = expected_chunks.pop_front();
          check_field("message_pgn", want.chunk_index, 64'(want.message_pgn),
                      64'(got.message_pgn));
          check_field("message_source", want.chunk_index, 64'(want.message_source),
                      64'(got.message_source));
          check_field("message_length", want.chunk_index, 64'(want.message_length),
                      64'(got.message_length));
          check_field("chunk_index", want.chunk_index, 64'(want.chunk_index),
                      64'(got.chunk_index));
          check_field("chunk_data", want.chunk_index, want.chunk_data, got.chunk_data);
          check_field("last_chunk", want.chunk_index, 64'(want.last_chunk),
                      64'(got.last_chunk));
        end
      end
      if (frame_i.valid && frame_i.ready) absorb_frame(frame_i.payload);
      chunks_pending_o <= expected_chunks.size();
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Top of the fast-packet reassembler testbench: clock, reset, frame requests and chunk stalls.
// Depends on fpr_pkg, the channel interfaces, the block itself and fpr_reassembly_checker.
`default_nettype none

module testbench;
  import fpr_pkg::*;

  localparam int unsigned TargetFrames = 500;
  localparam int unsigned QuietFrom    = 440;
  localparam int unsigned CycleLimit   = 2_000_000;
  localparam int unsigned DrainCycles  = 100;

  typedef enum logic [2:0] {
    ShapeClean,
    ShapeBadSeq,
    ShapeBadSrc,
    ShapeBadPgn,
    ShapeCut
  } msg_shape_e;

  logic        clk_i;
  logic        rst_ni;
  logic        quiet_q;
  logic        frame_gaps_on;
  int unsigned frames_sent;
  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned chunks_pending;
  int unsigned stall_left = 0;
  logic        stall_on = 1'b0;

  fpr_frame_if frame_bus ();
  fpr_chunk_if chunk_bus ();

  fast_packet_reassembler uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .frame_i(frame_bus),
    .chunk_o(chunk_bus)
  );

  fpr_reassembly_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .frame_i         (frame_bus),
    .chunk_i         (chunk_bus),
    .mismatch_count_o(mismatch_count),
    .chunks_pending_o(chunks_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (quiet_q) begin
      chunk_bus.ready <= 1'b1;
    end else begin
      if (stall_left == 0) begin
        stall_on   = ($urandom_range(0, 2) == 0);
        stall_left = stall_on ? $urandom_range(1, 16) : $urandom_range(1, 48);
      end
      stall_left = stall_left - 1;
      chunk_bus.ready <= !stall_on;
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("fast_packet_reassembler verification failed");
    $finish;
  end

  function automatic frame_t random_frame();
    frame_t f;
    f.pgn            = 18'($urandom);
    f.source_address = 8'($urandom);
    f.data_byte_0    = 8'($urandom);
    f.data_byte_1    = 8'($urandom);
    f.data_byte_2    = 8'($urandom);
    f.data_byte_3    = 8'($urandom);
    f.data_byte_4    = 8'($urandom);
    f.data_byte_5    = 8'($urandom);
    f.data_byte_6    = 8'($urandom);
    f.data_byte_7    = 8'($urandom);
    return f;
  endfunction

  function automatic frame_t cont_frame(input logic [17:0] pgn, input logic [7:0] src,
                                        input logic [2:0] seq, input logic [4:0] idx);
    frame_t f;
    f                = random_frame();
    f.pgn            = pgn;
    f.source_address = src;
    f.data_byte_0    = {seq, idx};
    return f;
  endfunction

  task automatic send_frame(input frame_t f, input bit counted);
    frame_bus.valid   <= 1'b1;
    frame_bus.payload <= f;
    do @(posedge clk_i); while (!frame_bus.ready);
    if (counted) frames_sent++;
    if (!quiet_q && frame_gaps_on && $urandom_range(0, 3) == 0) begin
      frame_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  task automatic wait_for_drain();
    if (frame_bus.valid) frame_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (chunks_pending != 0) @(posedge clk_i);
  endtask

  task automatic send_message(input logic [17:0] pgn, input logic [7:0] src,
                              input logic [2:0] seq, input logic [7:0] len,
                              input msg_shape_e shape, input int unsigned break_at);
    frame_t      f;
    int unsigned conts;
    int unsigned good;
    int unsigned i;
    logic [4:0]  idx;
    conts = len / 7;
    if (shape == ShapeClean || conts == 0) good = conts;
    else good = (break_at < conts) ? break_at : conts - 1;
    f                = random_frame();
    f.pgn            = pgn;
    f.source_address = src;
    f.data_byte_0    = {seq, FrameIdxFirst};
    f.data_byte_1    = len;
    send_frame(f, 1'b1);
    for (i = 1; i <= good; i++) begin
      idx = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(1, 31)) : 5'((i - 1) % 31 + 1);
      send_frame(cont_frame(pgn, src, seq, idx), 1'b1);
    end
    if (good < conts && shape != ShapeCut && shape != ShapeClean) begin
      f = cont_frame(pgn, src, seq, 5'($urandom_range(1, 31)));
      case (shape)
        ShapeBadSeq: f.data_byte_0[7:5] = seq ^ 3'($urandom_range(1, 7));
        ShapeBadSrc: f.source_address = src ^ 8'($urandom_range(1, 255));
        default:     f.pgn = pgn ^ 18'($urandom_range(1, 262143));
      endcase
      send_frame(f, 1'b1);
      // A correct frame after the break must still be dropped.
      send_frame(cont_frame(pgn, src, seq, 5'($urandom_range(1, 31))), 1'b1);
    end
  endtask

  initial begin
    frame_t      f;
    int unsigned pick;
    logic [7:0]  len;
    logic        long_done;
    msg_shape_e  shape;
    frame_bus.valid   = 1'b0;
    frame_bus.payload = '0;
    chunk_bus.ready   = 1'b0;
    quiet_q           = 1'b0;
    frame_gaps_on     = 1'b1;
    frames_sent       = 0;
    long_done         = 1'b0;
    rst_ni            = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_frame(cont_frame(18'h2A5A5, 8'h11, 3'd1, 5'd1), 1'b0);
    send_message(18'h3FFFF, 8'hFF, 3'd7, 8'd0, ShapeClean, 0);
    f                = '1;
    f.pgn            = '0;
    f.source_address = '0;
    f.data_byte_0    = {3'd0, FrameIdxFirst};
    f.data_byte_1    = 8'd6;
    send_frame(f, 1'b1);
    f                = '0;
    f.pgn            = '1;
    f.source_address = '1;
    f.data_byte_0    = {3'd5, FrameIdxFirst};
    f.data_byte_1    = 8'd6;
    send_frame(f, 1'b1);
    send_message(18'($urandom), 8'($urandom), 3'd3, 8'd1, ShapeClean, 0);
    send_message(18'($urandom), 8'($urandom), 3'd2, 8'd7, ShapeClean, 0);
    send_message(18'($urandom), 8'($urandom), 3'd4, 8'd13, ShapeClean, 0);
    send_message(18'($urandom), 8'($urandom), 3'd6, 8'd20, ShapeBadSeq, 1);
    send_message(18'($urandom), 8'($urandom), 3'd1, 8'd20, ShapeBadSrc, 0);
    send_message(18'($urandom), 8'($urandom), 3'd0, 8'd9, ShapeBadPgn, 0);
    send_message(18'($urandom), 8'($urandom), 3'd5, 8'd30, ShapeCut, 1);
    send_message(18'($urandom), 8'($urandom), 3'd7, 8'd8, ShapeClean, 0);
    send_frame(cont_frame(18'h15A5A, 8'hEE, 3'd7, 5'd31), 1'b0);
    wait_for_drain();

    while (frames_sent < TargetFrames) begin
      if (!quiet_q && frames_sent >= QuietFrom) quiet_q <= 1'b1;
      frame_gaps_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_frame(random_frame(), 1'b0);
      end else begin
        pick = $urandom_range(0, 99);
        if (!long_done) len = 8'd255;
        else if (pick < 57) len = 8'($urandom_range(0, 14));
        else if (pick < 89) len = 8'($urandom_range(15, 60));
        else if (pick < 97) len = 8'($urandom_range(61, 254));
        else len = 8'd255;
        long_done = 1'b1;
        shape = ($urandom_range(0, 99) < 15) ? msg_shape_e'($urandom_range(1, 4)) : ShapeClean;
        send_message(18'($urandom), 8'($urandom), 3'($urandom), len, shape,
                     $urandom_range(0, 36));
      end
      if (!quiet_q && $urandom_range(0, 29) == 0) wait_for_drain();
    end

    wait_for_drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && chunks_pending == 0) begin
      $display("fast_packet_reassembler verification clean");
    end else begin
      $display("fast_packet_reassembler verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
